[design/crs_pkg.sv]
`timescale 1ns / 1ps

package crs_pkg;

   localparam int COORD_BITS_DEF  = 16;
   localparam int FRAC_BITS_DEF   = 8;
   localparam int MAX_SAMPLES_DEF = 31;

   // Width and reset value of the samples-per-segment register.
   localparam int CFG_BITS = 5;
   localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd20;

   // Slots of the per-sample multiply schedule.
   localparam int STEP_BITS = 4;
   localparam logic [STEP_BITS-1:0] STEP_TT     = 4'd0;
   localparam logic [STEP_BITS-1:0] STEP_DX     = 4'd1;
   localparam logic [STEP_BITS-1:0] STEP_T2T    = 4'd2;
   localparam logic [STEP_BITS-1:0] STEP_AX     = 4'd3;
   localparam logic [STEP_BITS-1:0] STEP_BX     = 4'd4;
   localparam logic [STEP_BITS-1:0] STEP_DY     = 4'd5;
   localparam logic [STEP_BITS-1:0] STEP_AY     = 4'd6;
   localparam logic [STEP_BITS-1:0] STEP_BY     = 4'd7;
   localparam logic [STEP_BITS-1:0] STEP_Y_DONE = 4'd8;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIV    = 5'b00010,
      ST_SETUP  = 5'b00100,
      ST_SAMPLE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

endpackage

[design/crs_div.sv]
`timescale 1ns / 1ps

// Restoring divider for (1 << FRAC_BITS) / divisor, one quotient bit per cycle.
module crs_div #(
   parameter int FRAC_BITS = crs_pkg::FRAC_BITS_DEF,
   parameter int DIV_BITS  = crs_pkg::CFG_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_BITS-1:0] divisor,
   output logic                done,
   output logic [FRAC_BITS:0]  quot,
   output logic [DIV_BITS-1:0] rem
);

   localparam int QW = FRAC_BITS + 1;
   localparam int CW = $clog2(FRAC_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [DIV_BITS-1:0] div_ff, div_in;
   logic [DIV_BITS-1:0] rem_ff, rem_in;
   logic [QW-1:0]       quot_ff, quot_in;
   logic [DIV_BITS:0]   trial;
   logic [DIV_BITS:0]   diff;
   logic                bit_in;
   logic                ge;

   always_comb begin
      // The dividend has a single one at its top bit.
      bit_in  = (cnt_ff == CW'(FRAC_BITS));
      trial   = {rem_ff, bit_in};
      ge      = (trial >= {1'b0, div_ff});
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(FRAC_BITS);
         div_in  = divisor;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
         quot_in = {quot_ff[QW-2:0], ge};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

[design/crs_mul.sv]
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product. The result is the
// product shifted right by FRAC_BITS, rounded toward minus infinity.
module crs_mul #(
   parameter int AW        = 20,
   parameter int BW        = 10,
   parameter int FRAC_BITS = crs_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 load,
   input  logic signed [AW-1:0] op_a,
   input  logic signed [BW-1:0] op_b,
   output logic signed [AW-1:0] res
);

   logic signed [AW+BW-1:0] prod_ff, prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign res = prod_ff[FRAC_BITS +: AW];

endmodule

[design/catmull_rom_spline_sampler.sv]
`timescale 1ns / 1ps

// Uniform Catmull-Rom sampler for 2-D control points in signed fixed point.
// Each point is one request transaction; the point that completes a segment
// produces samples_per_segment+1 response transactions (clamped to 1 ..
// MAX_SAMPLES intervals), and a point flagged last also flushes the final
// segment, so one request yields 0 to 2*(MAX_SAMPLES+1) responses. rsp_run_end
// marks the last response of a request. The block takes one request at a time:
// a request that completes a segment passes through the bit-serial divider that
// forms the parameter step, then per segment a setup state and the per-sample
// multiply schedule, in which all eight products of a sample (t squared, t cubed
// and three blend terms per axis) share one multiplier, then a closing state.
// The default is 20 intervals.
// A stalled response port holds the sequencer in its last sample slot.
module catmull_rom_spline_sampler #(
   parameter int COORD_BITS  = crs_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS   = crs_pkg::FRAC_BITS_DEF,
   parameter int MAX_SAMPLES = crs_pkg::MAX_SAMPLES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic                         req_last_point,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_curve_x,
   output logic signed [COORD_BITS-1:0] rsp_curve_y,
   output logic                         rsp_run_end,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [crs_pkg::CFG_BITS-1:0] csr_samples_per_segment
);

   localparam int C   = COORD_BITS;
   localparam int DW  = crs_pkg::CFG_BITS;
   localparam int TW  = FRAC_BITS + 1;
   localparam int BW  = FRAC_BITS + 2;
   localparam int AW  = (COORD_BITS + 4 > FRAC_BITS + 2) ? COORD_BITS + 4 : FRAC_BITS + 2;
   localparam int VW  = AW + 1;
   localparam int SB  = crs_pkg::STEP_BITS;
   localparam logic [TW-1:0] FP_ONE = TW'(1) << FRAC_BITS;
   localparam logic [DW-1:0] MAX_STEPS = DW'(MAX_SAMPLES);
   localparam logic signed [VW-1:0] SAT_HI = {{(VW-C+1){1'b0}}, {(C-1){1'b1}}};
   localparam logic signed [VW-1:0] SAT_LO = {{(VW-C+1){1'b1}}, {(C-1){1'b0}}};

   function automatic logic signed [AW-1:0] ext_a(input logic signed [C-1:0] p);
      return {{(AW-C){p[C-1]}}, p};
   endfunction

   function automatic logic signed [AW-1:0] coef_d(input logic signed [AW-1:0] p0,
                                                   input logic signed [AW-1:0] p2);
      return p2 - p0;
   endfunction

   function automatic logic signed [AW-1:0] coef_a(input logic signed [AW-1:0] p0,
                                                   input logic signed [AW-1:0] p1,
                                                   input logic signed [AW-1:0] p2,
                                                   input logic signed [AW-1:0] p3);
      return (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
   endfunction

   function automatic logic signed [AW-1:0] coef_b(input logic signed [AW-1:0] p0,
                                                   input logic signed [AW-1:0] p1,
                                                   input logic signed [AW-1:0] p2,
                                                   input logic signed [AW-1:0] p3);
      return ((p1 <<< 1) + p1) - p0 - ((p2 <<< 1) + p2) + p3;
   endfunction

   // Halves the blend sum (the constant one-half factor) and clamps it.
   function automatic logic signed [C-1:0] finish(input logic signed [VW-1:0] v);
      logic signed [VW-1:0] h;
      h = v >>> 1;
      if (h > SAT_HI) begin
         return SAT_HI[C-1:0];
      end else if (h < SAT_LO) begin
         return SAT_LO[C-1:0];
      end
      return h[C-1:0];
   endfunction

   crs_pkg::state_type state_ff, state_in;

   logic [DW-1:0] csr_steps_ff, csr_steps_in;
   logic [DW-1:0] steps_ff, steps_in;
   logic [DW-1:0] steps_eff;
   logic [1:0]    seen_ff, seen_in;

   logic signed [C-1:0] in_x_ff, in_y_ff;
   logic                last_ff;
   logic signed [C-1:0] win_x_ff [3];
   logic signed [C-1:0] win_y_ff [3];
   logic                seg_b_ff, seg_b_in;

   logic signed [AW-1:0] dx_ff, ax_ff, bx_ff, dy_ff, ay_ff, by_ff;
   logic signed [C-1:0]  p1x_ff, p1y_ff;
   logic signed [AW-1:0] q0x, q1x, q2x, q3x, q0y, q1y, q2y, q3y;

   logic [SB-1:0] step_ff, step_in;
   logic [DW-1:0] s_ff, s_in;
   logic [TW-1:0] t_ff, t_in;
   logic [TW-1:0] t2_ff, t2_in;
   logic [TW-1:0] t3_ff, t3_in;
   logic [DW-1:0] trem_ff, trem_in;
   logic [DW:0]   rsum;
   logic          wrap;

   logic signed [VW-1:0] acc_ff, acc_in;
   logic signed [VW-1:0] acc_sum;
   logic signed [C-1:0]  xh_ff, xh_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [C-1:0]  rsp_x_ff, rsp_y_ff;
   logic                 rsp_end_ff;
   logic                 rsp_load;
   logic                 out_free;

   logic                 has_a, has_b, any_seg;
   logic                 req_fire;
   logic                 last_sample;
   logic                 run_end;

   logic                 div_start, div_done;
   logic [TW-1:0]        div_quot;
   logic [DW-1:0]        div_rem;

   logic                 mul_load;
   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [AW-1:0] mul_res;

   assign req_ready = (state_ff == crs_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   assign has_a   = seen_ff[1];
   assign has_b   = last_ff && (seen_ff != 2'd0);
   assign any_seg = seen_ff[1] || (req_last_point && (seen_ff != 2'd0));

   always_comb begin
      priority if (csr_steps_ff == '0) begin
         steps_eff = DW'(1);
      end else if (csr_steps_ff > MAX_STEPS) begin
         steps_eff = MAX_STEPS;
      end else begin
         steps_eff = csr_steps_ff;
      end
   end

   assign csr_steps_in = (csr_valid && csr_ready) ? csr_samples_per_segment : csr_steps_ff;
   assign steps_in     = req_fire ? steps_eff : steps_ff;
   assign div_start    = req_fire && any_seg;

   crs_div #(
      .FRAC_BITS (FRAC_BITS),
      .DIV_BITS  (DW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (steps_eff),
      .done    (div_done),
      .quot    (div_quot),
      .rem     (div_rem)
   );

   // Control points of the current segment; the end point doubles as its own
   // neighbor at the start and at the end of a curve.
   always_comb begin
      if (!seg_b_ff) begin
         q0x = ext_a((seen_ff == 2'd2) ? win_x_ff[1] : win_x_ff[2]);
         q0y = ext_a((seen_ff == 2'd2) ? win_y_ff[1] : win_y_ff[2]);
         q1x = ext_a(win_x_ff[1]);
         q1y = ext_a(win_y_ff[1]);
         q2x = ext_a(win_x_ff[0]);
         q2y = ext_a(win_y_ff[0]);
      end else begin
         q0x = ext_a((seen_ff == 2'd1) ? win_x_ff[0] : win_x_ff[1]);
         q0y = ext_a((seen_ff == 2'd1) ? win_y_ff[0] : win_y_ff[1]);
         q1x = ext_a(win_x_ff[0]);
         q1y = ext_a(win_y_ff[0]);
         q2x = ext_a(in_x_ff);
         q2y = ext_a(in_y_ff);
      end
      q3x = ext_a(in_x_ff);
      q3y = ext_a(in_y_ff);
   end

   // Multiplier schedule: one product issued per slot, consumed in the next.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (step_ff)
         crs_pkg::STEP_TT: begin
            mul_a = AW'({1'b0, t_ff});
            mul_b = {1'b0, t_ff};
         end
         crs_pkg::STEP_DX: begin
            mul_a = dx_ff;
            mul_b = {1'b0, t_ff};
         end
         crs_pkg::STEP_T2T: begin
            mul_a = AW'({1'b0, t2_ff});
            mul_b = {1'b0, t_ff};
         end
         crs_pkg::STEP_AX: begin
            mul_a = ax_ff;
            mul_b = {1'b0, t2_ff};
         end
         crs_pkg::STEP_BX: begin
            mul_a = bx_ff;
            mul_b = {1'b0, t3_ff};
         end
         crs_pkg::STEP_DY: begin
            mul_a = dy_ff;
            mul_b = {1'b0, t_ff};
         end
         crs_pkg::STEP_AY: begin
            mul_a = ay_ff;
            mul_b = {1'b0, t2_ff};
         end
         crs_pkg::STEP_BY: begin
            mul_a = by_ff;
            mul_b = {1'b0, t3_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_load = (state_ff == crs_pkg::ST_SAMPLE) && (step_ff != crs_pkg::STEP_Y_DONE);

   crs_mul #(
      .AW        (AW),
      .BW        (BW),
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock (clock),
      .load  (mul_load),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .res   (mul_res)
   );

   assign acc_sum     = acc_ff + {mul_res[AW-1], mul_res};
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign last_sample = (s_ff == steps_ff);
   assign run_end     = last_sample && (seg_b_ff || !has_b);
   assign rsp_load    = (state_ff == crs_pkg::ST_SAMPLE) &&
                        (step_ff == crs_pkg::STEP_Y_DONE) && out_free;

   // Next parameter value: t advances by the quotient, and the remainder
   // accumulates until it carries one more unit into t.
   assign rsum = {1'b0, trem_ff} + {1'b0, div_rem};
   assign wrap = (rsum >= {1'b0, steps_ff});

   always_comb begin
      state_in = state_ff;
      seg_b_in = seg_b_ff;
      step_in  = step_ff;
      s_in     = s_ff;
      t_in     = t_ff;
      trem_in  = trem_ff;
      t2_in    = t2_ff;
      t3_in    = t3_ff;
      acc_in   = acc_ff;
      xh_in    = xh_ff;
      seen_in  = seen_ff;
      unique case (state_ff)
         crs_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = any_seg ? crs_pkg::ST_DIV : crs_pkg::ST_DONE;
            end
         end
         crs_pkg::ST_DIV: begin
            if (div_done) begin
               seg_b_in = !has_a;
               state_in = crs_pkg::ST_SETUP;
            end
         end
         crs_pkg::ST_SETUP: begin
            step_in  = crs_pkg::STEP_TT;
            s_in     = '0;
            t_in     = '0;
            trem_in  = '0;
            state_in = crs_pkg::ST_SAMPLE;
         end
         crs_pkg::ST_SAMPLE: begin
            step_in = step_ff + SB'(1);
            unique case (step_ff)
               crs_pkg::STEP_TT: begin
                  acc_in = {{(VW-C-1){p1x_ff[C-1]}}, p1x_ff, 1'b0};
               end
               crs_pkg::STEP_DX: begin
                  t2_in = mul_res[TW-1:0];
               end
               crs_pkg::STEP_T2T, crs_pkg::STEP_BX, crs_pkg::STEP_AY,
               crs_pkg::STEP_BY: begin
                  acc_in = acc_sum;
               end
               crs_pkg::STEP_AX: begin
                  t3_in = mul_res[TW-1:0];
               end
               crs_pkg::STEP_DY: begin
                  xh_in  = finish(acc_sum);
                  acc_in = {{(VW-C-1){p1y_ff[C-1]}}, p1y_ff, 1'b0};
               end
               crs_pkg::STEP_Y_DONE: begin
                  step_in = step_ff;
                  if (out_free) begin
                     step_in = crs_pkg::STEP_TT;
                     if (last_sample) begin
                        if (!seg_b_ff && has_b) begin
                           seg_b_in = 1'b1;
                           state_in = crs_pkg::ST_SETUP;
                        end else begin
                           state_in = crs_pkg::ST_DONE;
                        end
                     end else begin
                        s_in    = s_ff + DW'(1);
                        trem_in = wrap ? DW'(rsum - {1'b0, steps_ff}) : rsum[DW-1:0];
                        t_in    = t_ff + div_quot + TW'(wrap);
                     end
                  end
               end
               default: begin
                  step_in = crs_pkg::STEP_TT;
               end
            endcase
         end
         crs_pkg::ST_DONE: begin
            if (last_ff) begin
               seen_in = 2'd0;
            end else if (seen_ff != 2'd3) begin
               seen_in = seen_ff + 2'd1;
            end
            state_in = crs_pkg::ST_IDLE;
         end
         default: begin
            state_in = crs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crs_pkg::ST_IDLE;
         seen_ff      <= 2'd0;
         csr_steps_ff <= crs_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
         step_ff      <= crs_pkg::STEP_TT;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         csr_steps_ff <= csr_steps_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff <= steps_in;
      seg_b_ff <= seg_b_in;
      s_ff     <= s_in;
      t_ff     <= t_in;
      trem_ff  <= trem_in;
      t2_ff    <= t2_in;
      t3_ff    <= t3_in;
      acc_ff   <= acc_in;
      xh_ff    <= xh_in;
      if (req_fire) begin
         in_x_ff <= req_point_x;
         in_y_ff <= req_point_y;
         last_ff <= req_last_point;
      end
      if (state_ff == crs_pkg::ST_SETUP) begin
         dx_ff  <= coef_d(q0x, q2x);
         ax_ff  <= coef_a(q0x, q1x, q2x, q3x);
         bx_ff  <= coef_b(q0x, q1x, q2x, q3x);
         dy_ff  <= coef_d(q0y, q2y);
         ay_ff  <= coef_a(q0y, q1y, q2y, q3y);
         by_ff  <= coef_b(q0y, q1y, q2y, q3y);
         p1x_ff <= q1x[C-1:0];
         p1y_ff <= q1y[C-1:0];
      end
      if ((state_ff == crs_pkg::ST_DONE) && !last_ff) begin
         win_x_ff[2] <= win_x_ff[1];
         win_x_ff[1] <= win_x_ff[0];
         win_x_ff[0] <= in_x_ff;
         win_y_ff[2] <= win_y_ff[1];
         win_y_ff[1] <= win_y_ff[0];
         win_y_ff[0] <= in_y_ff;
      end
      if (rsp_load) begin
         rsp_x_ff   <= xh_ff;
         rsp_y_ff   <= finish(acc_sum);
         rsp_end_ff <= run_end;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_curve_x = rsp_x_ff;
   assign rsp_curve_y = rsp_y_ff;
   assign rsp_run_end = rsp_end_ff;

`ifndef SYNTHESIS
   // Once a request is accepted, req_ready drops before another can be taken.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a previous one is in progress");

   // The parameter never steps past one.
   a_t_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == crs_pkg::ST_SAMPLE |-> t_ff <= FP_ONE)
      else $error("sample parameter exceeds one");

   // The slot counter stays inside the multiply schedule.
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == crs_pkg::ST_SAMPLE |-> step_ff <= crs_pkg::STEP_Y_DONE)
      else $error("multiply slot counter out of range");

   // The sample counter never runs past the interval count.
   a_sample_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == crs_pkg::ST_SAMPLE |-> s_ff <= steps_ff)
      else $error("sample index beyond the segment");
`endif

endmodule

[tb/catmull_rom_spline_sampler_test.sv]
`timescale 1ns / 1ps

module catmull_rom_spline_sampler_test;

   localparam int CW = crs_pkg::COORD_BITS_DEF;
   localparam int FB = crs_pkg::FRAC_BITS_DEF;
   localparam int CB = crs_pkg::CFG_BITS;
   localparam int MAX_STEPS = crs_pkg::MAX_SAMPLES_DEF;
   localparam longint FP_ONE = longint'(1) << FB;
   localparam int IDLE_SETTLE = 32;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic                 last;
   } point_type;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic                 run_end;
   } sample_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [CW-1:0] req_point_x = '0;
   logic signed [CW-1:0] req_point_y = '0;
   logic                 req_last_point = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [CW-1:0] rsp_curve_x;
   logic signed [CW-1:0] rsp_curve_y;
   logic                 rsp_run_end;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CB-1:0]        csr_samples_per_segment = '0;

   catmull_rom_spline_sampler uut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_point_x             (req_point_x),
      .req_point_y             (req_point_y),
      .req_last_point          (req_last_point),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_curve_x             (rsp_curve_x),
      .rsp_curve_y             (rsp_curve_y),
      .rsp_run_end             (rsp_run_end),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_samples_per_segment (csr_samples_per_segment)
   );

   point_type  point_queue[$];
   sample_type pending_samples[$];
   point_type  cur_point;

   // Shadow state of the sampler: newest control point first.
   logic signed [CW-1:0] hist_x[3];
   logic signed [CW-1:0] hist_y[3];
   int                   hist_count = 0;
   logic [CB-1:0]        interval_count = crs_pkg::CFG_RESET;

   bit quiet_tail = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   int mismatches = 0;
   int points_accepted = 0;
   int samples_checked = 0;
   int curves_sent = 0;
   int csr_writes = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint fp_mul(input longint a, input longint b);
      return (a * b) >>> FB;
   endfunction

   function automatic logic signed [CW-1:0] blend_coord(input longint p0, input longint p1,
                                                         input longint p2, input longint p3,
                                                         input longint t, input longint t2,
                                                         input longint t3);
      longint v;
      longint hi;
      hi = (longint'(1) << (CW - 1)) - 1;
      v = 2 * p1 + fp_mul(p2 - p0, t) + fp_mul(2 * p0 - 5 * p1 + 4 * p2 - p3, t2)
          + fp_mul(-p0 + 3 * p1 - 3 * p2 + p3, t3);
      v = fp_mul(FP_ONE >> 1, v);
      if (v > hi) v = hi;
      if (v < -hi - 1) v = -hi - 1;
      return CW'(v);
   endfunction

   task automatic sample_segment(input longint p0x, input longint p0y,
                                 input longint p1x, input longint p1y,
                                 input longint p2x, input longint p2y,
                                 input longint p3x, input longint p3y);
      longint steps;
      longint t;
      longint t2;
      longint t3;
      sample_type smp;
      steps = interval_count;
      if (steps < 1) steps = 1;
      if (steps > MAX_STEPS) steps = MAX_STEPS;
      for (longint s = 0; s <= steps; s++) begin
         t = (s * FP_ONE) / steps;
         t2 = fp_mul(t, t);
         t3 = fp_mul(t2, t);
         smp.x = blend_coord(p0x, p1x, p2x, p3x, t, t2, t3);
         smp.y = blend_coord(p0y, p1y, p2y, p3y, t, t2, t3);
         smp.run_end = 1'b0;
         pending_samples.push_back(smp);
      end
   endtask

   task automatic predict_point(input point_type pt);
      int n;
      int first_new;
      n = hist_count;
      first_new = pending_samples.size();
      // A point that completes an interior segment; at the start of a curve the
      // first point stands in for its missing outer neighbor.
      if (n >= 2)
         sample_segment((n == 2) ? hist_x[1] : hist_x[2], (n == 2) ? hist_y[1] : hist_y[2],
                        hist_x[1], hist_y[1], hist_x[0], hist_y[0], pt.x, pt.y);
      // The last point also closes the final segment, with itself duplicated.
      if (pt.last && n >= 1)
         sample_segment((n == 1) ? hist_x[0] : hist_x[1], (n == 1) ? hist_y[0] : hist_y[1],
                        hist_x[0], hist_y[0], pt.x, pt.y, pt.x, pt.y);
      if (pending_samples.size() > first_new)
         pending_samples[$].run_end = 1'b1;
      if (pt.last) begin
         hist_count = 0;
      end else begin
         hist_x[2] = hist_x[1];
         hist_y[2] = hist_y[1];
         hist_x[1] = hist_x[0];
         hist_y[1] = hist_y[0];
         hist_x[0] = pt.x;
         hist_y[0] = pt.y;
         if (n < 3) hist_count = n + 1;
      end
   endtask

   // Point driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_point(cur_point);
            points_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else if (point_queue.size() != 0) begin
               cur_point = point_queue.pop_front();
               req_valid <= 1'b1;
               req_point_x <= cur_point.x;
               req_point_y <= cur_point.y;
               req_last_point <= cur_point.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Sample monitor and response back-pressure.
   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         rsp_ready <= 1'b1;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            samples_checked++;
            if (pending_samples.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected sample x=%0d y=%0d run_end=%0b",
                           rsp_curve_x, rsp_curve_y, rsp_run_end);
            end else begin
               want = pending_samples.pop_front();
               if (rsp_curve_x !== want.x || rsp_curve_y !== want.y
                   || rsp_run_end !== want.run_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("sample %0d: want x=%0d y=%0d end=%0b, got x=%0d y=%0d end=%0b",
                              samples_checked, want.x, want.y, want.run_end,
                              rsp_curve_x, rsp_curve_y, rsp_run_end);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no transaction on any port.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [CW-1:0] rand_coord();
      if ($urandom_range(0, 3) == 0) return CW'($urandom);
      return CW'($urandom_range(0, 4095)) - CW'(2048);
   endfunction

   task automatic add_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                            input logic last);
      point_type pt;
      pt.x = x;
      pt.y = y;
      pt.last = last;
      point_queue.push_back(pt);
      if (last) curves_sent++;
   endtask

   task automatic add_curve(input int len);
      for (int i = 0; i < len; i++)
         add_point(rand_coord(), rand_coord(), i == len - 1);
   endtask

   // Waits until the sampler has drained every point and sample, then lets it settle
   // in case the last point produced no samples.
   task automatic wait_drained();
      while (point_queue.size() != 0 || req_valid || pending_samples.size() != 0)
         @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_intervals(input logic [CB-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_samples_per_segment <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      interval_count = value;
      csr_writes++;
   endtask

   initial begin
      int phase_items;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset interval count: single-point curve, two-point curve at full-scale
      // extremes, a three-point curve and a longer curve of moderate points.
      add_point('0, '0, 1'b1);
      add_point(16'sh8000, 16'sh7fff, 1'b0);
      add_point(16'sh7fff, 16'sh8000, 1'b1);
      add_point(16'sh0100, -16'sh0200, 1'b0);
      add_point(16'sh7fff, 16'sh7fff, 1'b0);
      add_point(16'sh8000, 16'sh8000, 1'b1);
      add_point('0, '0, 1'b0);
      add_point(16'sh0100, 16'sh0300, 1'b0);
      add_point(16'sh0200, -16'sh0100, 1'b0);
      add_point(16'sh0400, 16'sh0200, 1'b0);
      add_point(16'sh0500, 16'sh0500, 1'b1);

      // A count of zero behaves as one interval; alternating extremes saturate.
      write_intervals('0);
      add_point(16'sh7fff, 16'sh8000, 1'b0);
      add_point(16'sh8000, 16'sh7fff, 1'b0);
      add_point(16'sh7fff, 16'sh7fff, 1'b0);
      add_point(16'sh8000, 16'sh8000, 1'b1);

      // Largest count: the closing point yields the most samples.
      write_intervals(CB'(MAX_STEPS));
      add_point(-16'sh0300, 16'sh0080, 1'b0);
      add_point(16'sh0040, -16'sh0280, 1'b0);
      add_point(16'sh0220, 16'sh0110, 1'b0);
      add_point(-16'sh0010, 16'sh0330, 1'b1);

      write_intervals(CB'(1));
      add_point(16'sh0123, -16'sh0456, 1'b0);
      add_point(-16'sh0789, 16'sh0abc, 1'b0);
      add_point(16'sh0def, 16'sh0001, 1'b1);

      for (int phase = 0; phase < 6; phase++) begin
         write_intervals(CB'($urandom_range(0, (1 << CB) - 1)));
         if (phase == 5) quiet_tail = 1'b1;
         phase_items = point_queue.size();
         while (point_queue.size() - phase_items < 13)
            add_curve($urandom_range(1, 7));
         // Sometimes leave a curve open so the next setting applies mid-curve.
         if (phase < 5 && $urandom_range(0, 1) == 1)
            for (int i = $urandom_range(1, 3); i > 0; i--)
               add_point(rand_coord(), rand_coord(), 1'b0);
      end
      add_curve(2);

      wait_drained();
      $display("Run covered %0d control points in %0d closed curves, %0d samples checked,",
               points_accepted, curves_sent, samples_checked);
      $display("and %0d interval-count writes including zero, one and the maximum.",
               csr_writes);
      if (mismatches == 0 && pending_samples.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d samples missing", mismatches, pending_samples.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
